// ----- src/cau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants and the saturation helper of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MAX_EXPONENT = 255;

  // operation codes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_CONJ = 3'd4;
  localparam logic [2:0] OP_POW  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIVZ = 2'd1;
  localparam logic [1:0] ST_ZPZ  = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic [32:0] sat32(input logic signed [65:0] v);
    logic [32:0] r;
    if (v > 66'sd2147483647) r = {1'b1, 32'h7fffffff};
    else if (v < -66'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

endpackage

// ----- src/cau_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_divider
// Restoring divider, one quotient bit per cycle: (mag << 16) / den,
// quotient capped at 2^32.
// ----------------------------------------------------------------------------
module cau_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] mag,
  input  logic [63:0] den,
  output logic        done,
  output logic [32:0] quot
);

  localparam int NB = 64 + cau_pkg::FRAC_BITS;

  logic [NB-1:0] num_r;
  logic [64:0]   rem_r;
  logic [32:0]   q_r;
  logic [6:0]    cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [64:0] rem_sh;
  logic        ge;
  logic [33:0] q_sh;

  always_comb begin
    rem_sh = {rem_r[63:0], num_r[NB-1]};
    ge     = rem_sh >= {1'b0, den};
    q_sh   = {q_r, ge};
    if (q_sh > 34'h0ffffffff) q_sh = 34'h100000000;
  end

  // one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'(NB - 1);
        num_r  <= {mag, {cau_pkg::FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        num_r <= num_r << 1;
        rem_r <= ge ? rem_sh - {1'b0, den} : rem_sh;
        q_r   <= q_sh[32:0];
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- src/complex_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Fixed-point complex ALU: add, subtract, multiply, divide, conjugate, power.
// ----------------------------------------------------------------------------
//  channel | ports                                    | direction
//  in      | in_valid/in_ready, action..exponent      | request in
//  out     | out_valid/out_ready, res_re/res_im/status | result out
//  cfg     | cfg_valid/cfg_ready, cfg_data            | threshold write
//
// One 32x32 multiplier is shared. Add, subtract, conjugate, unused codes and
// power with exponent 0 or 1 are loaded at the accepting edge, then pass
// S_FIN; multiply runs the product phases, S_COMB and S_DEN; power, n >= 2,
// repeats them n-1 times; divide forms 6 products, then two divider passes,
// or gives ST_DIVZ below the threshold. in_ready is high only while idle; a
// result holds until out_ready; idle returns in the cycle after the transfer.
// Synchronous active-low reset sets the threshold to 1.
module complex_arithmetic_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  input  logic [7:0]         in_exponent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_re,
  output logic signed [31:0] out_res_im,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_COMB, S_DEN, S_DIVR, S_DIVI, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  logic [31:0] thr_r;
  logic [2:0]  op_r;
  logic signed [31:0] br_r, bi_r, xr_r, xi_r;
  logic [7:0]  e_r;
  logic [2:0]  ph_r;
  logic signed [63:0] p_r [6];
  logic signed [63:0] prod_r;
  logic        sat_r;
  logic [1:0]  st_r;
  logic signed [31:0] rr_r, ri_r;
  logic [63:0] den_r, mr_r, mi_r;
  logic        nr_r, ni_r, dstart_r;

  // shared multiplier with registered product
  logic signed [31:0] mx, my;
  always_comb begin
    mx = xr_r; my = br_r;
    case (ph_r)
      3'd0: begin mx = xr_r; my = br_r; end
      3'd1: begin mx = xi_r; my = bi_r; end
      3'd2: begin mx = xr_r; my = bi_r; end
      3'd3: begin mx = xi_r; my = br_r; end
      3'd4: begin mx = br_r; my = br_r; end
      default: begin mx = bi_r; my = bi_r; end
    endcase
  end

  // last product phase: divide also needs the divisor squares
  logic [2:0] ph_last;
  assign ph_last = (op_r == cau_pkg::OP_DIV) ? 3'd5 : 3'd3;

  // combine products: real/imag sums, 66 bits exact
  logic signed [65:0] s_re, s_im, d_re, d_im;
  logic [32:0] c_re, c_im;
  always_comb begin
    s_re = 66'(p_r[0]) - 66'(p_r[1]);
    s_im = 66'(p_r[2]) + 66'(p_r[3]);
    d_re = 66'(p_r[0]) + 66'(p_r[1]);
    d_im = 66'(p_r[3]) - 66'(p_r[2]);
    c_re = cau_pkg::sat32(s_re >>> cau_pkg::FRAC_BITS);
    c_im = cau_pkg::sat32(s_im >>> cau_pkg::FRAC_BITS);
  end

  logic [65:0] abs_re, abs_im;
  assign abs_re = d_re[65] ? 66'(-d_re) : d_re;
  assign abs_im = d_im[65] ? 66'(-d_im) : d_im;

  // divisor energy |b|^2 from the two squares
  logic [63:0] den_sum;
  assign den_sum = $unsigned(p_r[4]) + $unsigned(p_r[5]);

  logic        ddone;
  logic [32:0] dquot;
  cau_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart_r),
    .mag(state_r == S_DIVI ? mi_r : mr_r), .den(den_r),
    .done(ddone), .quot(dquot)
  );

  // signed quotient
  function automatic logic [32:0] signq(input logic [32:0] q, input logic neg);
    logic [32:0] r;
    if (neg) begin
      if (q > 33'h080000000) r = {1'b1, 32'h80000000};
      else r = {1'b0, 32'(-q)};
    end else begin
      if (q > 33'h07fffffff) r = {1'b1, 32'h7fffffff};
      else r = {1'b0, q[31:0]};
    end
    return r;
  endfunction

  logic [32:0] qs;
  assign qs = signq(dquot, state_r == S_DIVI ? ni_r : nr_r);

  // result loaded at the request transfer
  logic [32:0] add_re, add_im, sub_re, sub_im, neg_im;
  logic signed [31:0] load_re, load_im;
  logic        load_sat;
  logic [1:0]  load_st;
  state_t      load_state;
  always_comb begin
    add_re = cau_pkg::sat32(66'(in_a_re) + 66'(in_b_re));
    add_im = cau_pkg::sat32(66'(in_a_im) + 66'(in_b_im));
    sub_re = cau_pkg::sat32(66'(in_a_re) - 66'(in_b_re));
    sub_im = cau_pkg::sat32(66'(in_a_im) - 66'(in_b_im));
    neg_im = cau_pkg::sat32(-66'(in_a_im));
    load_re    = '0;
    load_im    = '0;
    load_sat   = 1'b0;
    load_st    = cau_pkg::ST_OK;
    load_state = S_FIN;
    case (in_action)
      cau_pkg::OP_ADD: begin
        load_re  = add_re[31:0];
        load_im  = add_im[31:0];
        load_sat = add_re[32] | add_im[32];
      end
      cau_pkg::OP_SUB: begin
        load_re  = sub_re[31:0];
        load_im  = sub_im[31:0];
        load_sat = sub_re[32] | sub_im[32];
      end
      cau_pkg::OP_MUL: load_state = S_MUL;
      cau_pkg::OP_DIV: load_state = S_MUL;
      cau_pkg::OP_CONJ: begin
        load_re  = in_a_re;
        load_im  = neg_im[31:0];
        load_sat = neg_im[32];
      end
      cau_pkg::OP_POW: begin
        if (in_exponent == 8'd0) begin
          if (in_a_re == 0 && in_a_im == 0) load_st = cau_pkg::ST_ZPZ;
          else load_re = 32'sd1 <<< cau_pkg::FRAC_BITS;
        end else if (in_exponent == 8'd1) begin
          load_re = in_a_re;
          load_im = in_a_im;
        end else begin
          load_state = S_MUL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      thr_r    <= 32'd1;
      dstart_r <= 1'b0;
    end else begin
      dstart_r <= 1'b0;
      if (cfg_valid && state_r == S_IDLE) thr_r <= cfg_data;
      case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_action;
          br_r <= (in_action == cau_pkg::OP_POW) ? in_a_re : in_b_re;
          bi_r <= (in_action == cau_pkg::OP_POW) ? in_a_im : in_b_im;
          xr_r <= in_a_re; xi_r <= in_a_im;
          e_r  <= in_exponent;
          ph_r <= 3'd0;
          rr_r <= load_re; ri_r <= load_im;
          sat_r <= load_sat; st_r <= load_st;
          state_r <= load_state;
        end
        S_MUL: begin
          // pipelined: the product of phase ph goes to prod_r, then to p_r[ph]
          prod_r <= 64'(mx) * 64'(my);
          ph_r <= ph_r + 3'd1;
          if (ph_r != 3'd0) p_r[ph_r - 3'd1] <= prod_r;
          if (ph_r == ph_last) state_r <= S_COMB;
        end
        S_COMB: begin
          p_r[ph_r - 3'd1] <= prod_r;
          state_r <= S_DEN;
          ph_r <= 3'd0;
        end
        S_DEN: begin
          if (op_r == cau_pkg::OP_DIV) begin
            den_r <= den_sum;
            mr_r <= abs_re[63:0]; mi_r <= abs_im[63:0];
            nr_r <= d_re[65]; ni_r <= d_im[65];
            if (den_sum == 64'd0 || den_sum < 64'(thr_r)) begin
              st_r <= cau_pkg::ST_DIVZ;
              state_r <= S_FIN;
            end else begin
              dstart_r <= 1'b1;
              state_r <= S_DIVR;
            end
          end else begin
            xr_r <= c_re[31:0]; xi_r <= c_im[31:0];
            rr_r <= c_re[31:0]; ri_r <= c_im[31:0];
            sat_r <= sat_r | c_re[32] | c_im[32];
            if (op_r == cau_pkg::OP_POW && e_r > 8'd2) begin
              e_r <= e_r - 8'd1;
              state_r <= S_MUL;
            end else state_r <= S_FIN;
          end
        end
        S_DIVR: if (ddone) begin
          rr_r <= qs[31:0]; sat_r <= sat_r | qs[32];
          dstart_r <= 1'b1;
          state_r <= S_DIVI;
        end
        S_DIVI: if (ddone) begin
          ri_r <= qs[31:0]; sat_r <= sat_r | qs[32];
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (st_r == cau_pkg::ST_OK && sat_r) st_r <= cau_pkg::ST_SAT;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // divide products: a_re*b_re, a_im*b_im, a_re*b_im, a_im*b_re, b_re^2, b_im^2
  // re sum = p0+p1, im = p3-p2 ; multiply re = p0-p1, im = p2+p3

  assign in_ready   = state_r == S_IDLE;
  assign cfg_ready  = state_r == S_IDLE;
  assign out_valid  = state_r == S_OUT;
  assign out_res_re = rr_r;
  assign out_res_im = ri_r;
  assign out_status = st_r;

endmodule
